// File: hw/rtl/crs_pkg.sv
package crs_pkg;

  localparam int unsigned TIME_BITS = 48;
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS = 32;

  localparam logic [3:0] KIND_CONNECT      = 4'd0;
  localparam logic [3:0] KIND_DISCONNECT   = 4'd1;
  localparam logic [3:0] KIND_RETRY        = 4'd2;
  localparam logic [3:0] KIND_HINT         = 4'd3;
  localparam logic [3:0] KIND_SESSION_OPEN = 4'd4;
  localparam logic [3:0] KIND_PACKET       = 4'd5;
  localparam logic [3:0] KIND_FRAME        = 4'd6;
  localparam logic [3:0] KIND_ERROR        = 4'd7;
  localparam logic [3:0] KIND_TICK         = 4'd8;

  localparam logic [3:0] DIAG_NONE       = 4'd0;
  localparam logic [3:0] DIAG_NO_PACKETS = 4'd1;
  localparam logic [3:0] DIAG_GAVE_UP    = 4'd2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_ATTEMPTS  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RETRY_DELAY   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SLOW_DELAY    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CONFIRM_TMO   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STALL_TMO     = 3'd4;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_OPEN  = 2'd1,
    ACT_CLOSE = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    MODE_IDLE         = 3'd0,
    MODE_CONNECTING   = 3'd1,
    MODE_SESSION      = 3'd2,
    MODE_STREAMING    = 3'd3,
    MODE_RECONNECTING = 3'd4,
    MODE_STALLED      = 3'd5,
    MODE_FAILED       = 3'd6
  } mode_e;

  typedef struct packed {
    logic [3:0]           kind;
    logic [TIME_BITS-1:0] now;
    logic [3:0]           error_reason;
  } crs_in_t;

  typedef struct packed {
    logic [1:0] action;
    logic [2:0] mode;
    logic [7:0] attempt_count;
    logic [3:0] diagnosis;
  } crs_out_t;

endpackage

// File: hw/rtl/connection_retry_supervisor.sv
// connection retry supervisor
// in channel: in_valid_i / in_stall_o carry one event item (kind, timestamp,
// error reason); out channel: out_valid_o / out_stall_i carry one result item
// (action, mode, attempt count, diagnosis) for every event item
// an item moves when valid is high and stall is low at a rising clock edge
// path: an accepted item goes into the input register, then through one pass of
// adders and compares into the result register
// throughput: one item per cycle while out_stall_i stays low; the mode and counter
// update for an item completes in the same cycle that its result is registered
// receiver stall: the result register holds, the input register holds its
// item, and in_stall_o rises once both are full
// cfg port: cfg_we_i writes register cfg_idx_i (0 max_attempts, 1 retry_delay,
// 2 slow_retry_delay, 3 data_confirm_timeout, 4 stall_timeout);
// write only while no item is in flight
// reset (rst_ni low, asynchronous): mode idle, counters and deadlines cleared,
// registers back to 5 / 1000 / 30000 / 5000 / 5000, both channels empty
module connection_retry_supervisor (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  crs_pkg::crs_in_t                   in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output crs_pkg::crs_out_t                  out_item_o,
  input  logic                               cfg_we_i,
  input  logic [crs_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [crs_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i
);
  import crs_pkg::*;

  localparam int unsigned TB = TIME_BITS;
  localparam int unsigned SUM_W = ((TB > 32) ? TB : 32) + 1;
  localparam logic [TB:0] DL_MAX = (TB >= 64) ? {1'b0, {TB{1'b1}}} : {1'b1, {TB{1'b0}}};

  function automatic logic [TB:0] sat_add(input logic [TB-1:0] base, input logic [31:0] dly);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(dly);
    if (sum > SUM_W'(DL_MAX)) begin
      return DL_MAX;
    end
    return sum[TB:0];
  endfunction

  // configuration
  logic [7:0]  max_attempts_q;
  logic [31:0] retry_delay_q, slow_delay_q, confirm_tmo_q, stall_tmo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_attempts_q <= 8'd5;
      retry_delay_q  <= 32'd1000;
      slow_delay_q   <= 32'd30000;
      confirm_tmo_q  <= 32'd5000;
      stall_tmo_q    <= 32'd5000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_ATTEMPTS: max_attempts_q <= cfg_wdata_i[7:0];
        CFG_RETRY_DELAY:  retry_delay_q  <= cfg_wdata_i;
        CFG_SLOW_DELAY:   slow_delay_q   <= cfg_wdata_i;
        CFG_CONFIRM_TMO:  confirm_tmo_q  <= cfg_wdata_i;
        CFG_STALL_TMO:    stall_tmo_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input register and handshake
  logic     s1_valid_q;
  crs_in_t  s1_q;
  logic     out_valid_q;
  crs_out_t out_q;
  logic     adv;

  assign adv        = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_q <= in_item_i;
    end
  end

  // supervisor state
  mode_e          mode_q, mode_d;
  logic [7:0]     attempts_q, attempts_d;
  logic [3:0]     diag_q, diag_d;
  logic [TB:0]    confirm_q, confirm_d;
  logic           confirm_v_q, confirm_v_d;
  logic [TB-1:0]  lp_q, lp_d;
  logic           lp_v_q, lp_v_d;
  logic [TB:0]    retry_q, retry_d;
  logic           retry_v_q, retry_v_d;
  action_e        action_d;

  logic [TB:0]    now_ext;
  logic [TB:0]    stall_dl;
  logic           mode_wait, mode_active;
  logic           start, hint_fire, err_hit, confirm_to, stall_to, retry_fire, fail;
  logic [7:0]     att_inc;
  logic           gave_up;
  logic [3:0]     fail_reason;
  mode_e          wait_mode;

  assign now_ext     = {1'b0, s1_q.now};
  assign stall_dl    = sat_add(lp_q, stall_tmo_q);
  assign mode_wait   = (mode_q == MODE_RECONNECTING) || (mode_q == MODE_STALLED) ||
                       (mode_q == MODE_FAILED);
  assign mode_active = (mode_q == MODE_CONNECTING) || (mode_q == MODE_SESSION) ||
                       (mode_q == MODE_STREAMING);

  assign start      = (s1_q.kind == KIND_CONNECT) ||
                      ((s1_q.kind == KIND_RETRY) && (mode_q == MODE_FAILED));
  assign hint_fire  = (s1_q.kind == KIND_HINT) && (mode_q == MODE_FAILED);
  assign err_hit    = (s1_q.kind == KIND_ERROR) && mode_active;
  assign confirm_to = (s1_q.kind == KIND_TICK) && (mode_q == MODE_SESSION) &&
                      confirm_v_q && (now_ext >= confirm_q);
  assign stall_to   = (s1_q.kind == KIND_TICK) && (mode_q == MODE_STREAMING) &&
                      lp_v_q && (now_ext >= stall_dl);
  assign retry_fire = (s1_q.kind == KIND_TICK) && mode_wait && retry_v_q &&
                      (now_ext >= retry_q);
  assign fail       = err_hit || confirm_to || stall_to;

  assign att_inc     = (attempts_q == 8'hFF) ? 8'hFF : attempts_q + 8'd1;
  assign gave_up     = att_inc > max_attempts_q;
  assign fail_reason = err_hit ? s1_q.error_reason : DIAG_NO_PACKETS;
  assign wait_mode   = (mode_q == MODE_STREAMING) ? MODE_STALLED : MODE_RECONNECTING;

  // next mode
  always_comb begin
    mode_d = mode_q;
    case (s1_q.kind)
      KIND_CONNECT:    mode_d = MODE_CONNECTING;
      KIND_DISCONNECT: mode_d = MODE_IDLE;
      KIND_RETRY, KIND_HINT: begin
        if (mode_q == MODE_FAILED) begin
          mode_d = MODE_CONNECTING;
        end
      end
      KIND_SESSION_OPEN: begin
        if (mode_q == MODE_CONNECTING) begin
          mode_d = MODE_SESSION;
        end
      end
      KIND_PACKET: begin
        if (mode_q == MODE_SESSION) begin
          mode_d = MODE_STREAMING;
        end
      end
      KIND_ERROR, KIND_TICK: begin
        if (fail) begin
          mode_d = gave_up ? MODE_FAILED : wait_mode;
        end else if (retry_fire) begin
          mode_d = MODE_CONNECTING;
        end
      end
      default: ;
    endcase
  end

  // action, counters and deadlines
  always_comb begin
    action_d    = ACT_NONE;
    attempts_d  = attempts_q;
    diag_d      = diag_q;
    confirm_d   = confirm_q;
    confirm_v_d = confirm_v_q;
    lp_d        = lp_q;
    lp_v_d      = lp_v_q;
    retry_d     = retry_q;
    retry_v_d   = retry_v_q;
    if (start || (s1_q.kind == KIND_DISCONNECT)) begin
      action_d    = start ? ACT_OPEN : ACT_CLOSE;
      attempts_d  = 8'd0;
      diag_d      = DIAG_NONE;
      confirm_v_d = 1'b0;
      lp_v_d      = 1'b0;
      retry_v_d   = 1'b0;
    end else if (hint_fire || retry_fire) begin
      action_d  = ACT_OPEN;
      retry_v_d = 1'b0;
    end else if (fail) begin
      action_d    = ACT_CLOSE;
      attempts_d  = att_inc;
      diag_d      = gave_up ? DIAG_GAVE_UP : fail_reason;
      confirm_v_d = 1'b0;
      lp_v_d      = 1'b0;
      retry_d     = sat_add(s1_q.now, gave_up ? slow_delay_q : retry_delay_q);
      retry_v_d   = 1'b1;
    end else begin
      case (s1_q.kind)
        KIND_SESSION_OPEN: begin
          if (mode_q == MODE_CONNECTING) begin
            confirm_d   = sat_add(s1_q.now, confirm_tmo_q);
            confirm_v_d = 1'b1;
          end
        end
        KIND_PACKET: begin
          if (mode_q == MODE_SESSION) begin
            confirm_v_d = 1'b0;
          end
          if ((mode_q == MODE_SESSION) || (mode_q == MODE_STREAMING)) begin
            lp_d   = s1_q.now;
            lp_v_d = 1'b1;
          end
        end
        KIND_FRAME: begin
          if (mode_q == MODE_STREAMING) begin
            attempts_d = 8'd0;
            diag_d     = DIAG_NONE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      attempts_q  <= 8'd0;
      diag_q      <= DIAG_NONE;
      confirm_v_q <= 1'b0;
      lp_v_q      <= 1'b0;
      retry_v_q   <= 1'b0;
    end else if (adv) begin
      mode_q      <= mode_d;
      attempts_q  <= attempts_d;
      diag_q      <= diag_d;
      confirm_v_q <= confirm_v_d;
      lp_v_q      <= lp_v_d;
      retry_v_q   <= retry_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      confirm_q <= confirm_d;
      lp_q      <= lp_d;
      retry_q   <= retry_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.action        <= action_d;
      out_q.mode          <= mode_d;
      out_q.attempt_count <= attempts_d;
      out_q.diagnosis     <= diag_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_retry_only_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    retry_v_q |-> (mode_q == MODE_RECONNECTING || mode_q == MODE_STALLED ||
                   mode_q == MODE_FAILED))
    else $error("retry deadline armed outside a waiting mode");

  a_confirm_only_session: assert property (@(posedge clk_i) disable iff (!rst_ni)
    confirm_v_q |-> (mode_q == MODE_SESSION))
    else $error("confirm deadline armed outside session mode");

  a_packet_only_streaming: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lp_v_q |-> (mode_q == MODE_STREAMING))
    else $error("packet time valid outside streaming mode");

  a_fail_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && mode_d == MODE_FAILED && mode_q != MODE_FAILED) |-> (action_d == ACT_CLOSE))
    else $error("entered failed mode without closing the source");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q && (out_q.mode == $past(mode_d)))
    else $error("result register missed an item");

endmodule
